### src/program_header_table_checker_core_macros.svh
// ----------------------------------------------------------------------------
// Program header table checker assertion macros
// Shared concurrent assertion forms, clocked on clk and idle during reset.
// ----------------------------------------------------------------------------
`ifndef PROGRAM_HEADER_TABLE_CHECKER_CORE_MACROS_SVH
`define PROGRAM_HEADER_TABLE_CHECKER_CORE_MACROS_SVH

// The condition holds at every clock edge out of reset.
`define PHTC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define PHTC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define PHTC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/phtc_pkg.sv
// ----------------------------------------------------------------------------
// Program header table checker package
// Widths, type codes, error bit positions and shared structures.
// ----------------------------------------------------------------------------
`default_nettype none

package phtc_pkg;

  localparam int unsigned WORD_W        = 64;
  localparam int unsigned TYPE_W        = 32;
  localparam int unsigned ERR_W         = 17;
  localparam int unsigned PADDR_W       = 5;
  localparam int unsigned REG_IDX_W     = 2;
  localparam int unsigned MAX_LOADS_DEF = 64;

  localparam logic [REG_IDX_W-1:0] REG_FILE_SIZE    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_TABLE_OFFSET = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_TABLE_BYTES  = 2'd2;

  localparam logic [TYPE_W-1:0] TY_LOAD    = 32'd1;
  localparam logic [TYPE_W-1:0] TY_DYNAMIC = 32'd2;
  localparam logic [TYPE_W-1:0] TY_INTERP  = 32'd3;
  localparam logic [TYPE_W-1:0] TY_SHLIB   = 32'd5;
  localparam logic [TYPE_W-1:0] TY_PHDR    = 32'd6;
  localparam logic [TYPE_W-1:0] TY_TLS     = 32'd7;
  localparam logic [TYPE_W-1:0] TY_OS_LOW  = 32'h6000_0000;
  localparam logic [TYPE_W-1:0] TY_PROC_HI = 32'h7FFF_FFFF;

  localparam int unsigned ERR_BEYOND_FILE  = 0;
  localparam int unsigned ERR_ADDR_WRAP    = 1;
  localparam int unsigned ERR_LOAD_ORDER   = 2;
  localparam int unsigned ERR_MEM_SMALL    = 3;
  localparam int unsigned ERR_ALIGN        = 4;
  localparam int unsigned ERR_DUP_DYNAMIC  = 5;
  localparam int unsigned ERR_DUP_INTERP   = 6;
  localparam int unsigned ERR_LATE_INTERP  = 7;
  localparam int unsigned ERR_INTERP_TERM  = 8;
  localparam int unsigned ERR_RESERVED     = 9;
  localparam int unsigned ERR_DUP_PHDR     = 10;
  localparam int unsigned ERR_LATE_PHDR    = 11;
  localparam int unsigned ERR_PHDR_EXTENT  = 12;
  localparam int unsigned ERR_INVALID_TYPE = 13;
  localparam int unsigned ERR_PHDR_OUTSIDE = 14;
  localparam int unsigned ERR_DYN_OUTSIDE  = 15;
  localparam int unsigned ERR_STORE_FULL   = 16;

  typedef struct packed {
    logic [TYPE_W-1:0] seg_type;
    logic [WORD_W-1:0] seg_offset;
    logic [WORD_W-1:0] seg_file_bytes;
    logic [WORD_W-1:0] seg_address;
    logic [WORD_W-1:0] seg_mem_bytes;
    logic [WORD_W-1:0] seg_alignment;
    logic              interp_terminated;
    logic              final_header;
  } item_t;

  typedef struct packed {
    logic [ERR_W-1:0] error_bits;
    logic             table_ok;
    logic             is_final;
  } result_t;

  typedef struct packed {
    logic [WORD_W-1:0] file_size;
    logic [WORD_W-1:0] table_offset;
    logic [WORD_W-1:0] table_bytes;
  } cfg_regs_t;

  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic              sub;
  } alu_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] sum;
    logic              carry;
  } alu_rsp_t;

endpackage

`default_nettype wire

### src/phtc_if.sv
// ----------------------------------------------------------------------------
// Program header table checker channels
// Valid/ready channels for decoded headers and for per-header results.
// ----------------------------------------------------------------------------
`default_nettype none

interface phtc_in_if;
  import phtc_pkg::*;

  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] seg_type;
  logic [WORD_W-1:0] seg_offset;
  logic [WORD_W-1:0] seg_file_bytes;
  logic [WORD_W-1:0] seg_address;
  logic [WORD_W-1:0] seg_mem_bytes;
  logic [WORD_W-1:0] seg_alignment;
  logic              interp_terminated;
  logic              final_header;

  modport source (
    output valid, seg_type, seg_offset, seg_file_bytes, seg_address,
    output seg_mem_bytes, seg_alignment, interp_terminated, final_header,
    input  ready
  );

  modport sink (
    input  valid, seg_type, seg_offset, seg_file_bytes, seg_address,
    input  seg_mem_bytes, seg_alignment, interp_terminated, final_header,
    output ready
  );
endinterface

interface phtc_out_if;
  import phtc_pkg::*;

  logic             valid;
  logic             ready;
  logic [ERR_W-1:0] error_bits;
  logic             table_ok;
  logic             is_final;

  modport source (
    output valid, error_bits, table_ok, is_final,
    input  ready
  );

  modport sink (
    input  valid, error_bits, table_ok, is_final,
    output ready
  );
endinterface

`default_nettype wire

### src/program_header_table_checker_core.sv
// ----------------------------------------------------------------------------
// Program header table checker
// Flags rule breaks in decoded program headers, one result per header.
//
//   Channel  Direction  Transfer on                   Contents
//   in_if    sink       valid && ready                one decoded header
//   out_if   source     valid && ready                error bits, table pass
//   APB      slave      psel && penable && pwrite     file and table extents
//
// A header passes seven shared-adder steps, a state update and the result
// hand-off, then the sequencer returns to idle to accept the next. When an
// error-free final header leaves a PHDR or DYNAMIC range, the containment scan
// runs WRD, WA, WB and WC per load segment examined, then closes in FIN.
// Reset is synchronous and clears the table state; the store needs no clear.
// A stalled result sits in the output register; the next header is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module program_header_table_checker_core #(
  parameter int unsigned MAX_LOADS = phtc_pkg::MAX_LOADS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  phtc_in_if.sink                       in_if,
  phtc_out_if.source                    out_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [phtc_pkg::PADDR_W-1:0]  paddr,
  input  logic [phtc_pkg::WORD_W-1:0]   pwdata,
  output logic [phtc_pkg::WORD_W-1:0]   prdata,
  output logic                          pready
);
  import phtc_pkg::*;

  cfg_regs_t              cfg_r;
  logic                   cfg_wr;
  logic [REG_IDX_W-1:0]   cfg_idx;
  item_t                  item;
  result_t                res;
  logic                   res_valid, res_ready;
  alu_req_t               alu_req;
  alu_rsp_t               alu_rsp;
  logic                   out_valid_r;
  result_t                out_res_r;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FILE_SIZE:    cfg_r.file_size    <= pwdata;
        REG_TABLE_OFFSET: cfg_r.table_offset <= pwdata;
        REG_TABLE_BYTES:  cfg_r.table_bytes  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FILE_SIZE:    prdata = cfg_r.file_size;
      REG_TABLE_OFFSET: prdata = cfg_r.table_offset;
      REG_TABLE_BYTES:  prdata = cfg_r.table_bytes;
      default:          prdata = '0;
    endcase
  end

  assign item.seg_type          = in_if.seg_type;
  assign item.seg_offset        = in_if.seg_offset;
  assign item.seg_file_bytes    = in_if.seg_file_bytes;
  assign item.seg_address       = in_if.seg_address;
  assign item.seg_mem_bytes     = in_if.seg_mem_bytes;
  assign item.seg_alignment     = in_if.seg_alignment;
  assign item.interp_terminated = in_if.interp_terminated;
  assign item.final_header      = in_if.final_header;

  phtc_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  phtc_ctrl #(
    .MAX_LOADS (MAX_LOADS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .item      (item),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .alu_req   (alu_req),
    .alu_rsp   (alu_rsp)
  );

  assign res_ready = !out_valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.error_bits = out_res_r.error_bits;
  assign out_if.table_ok   = out_res_r.table_ok;
  assign out_if.is_final   = out_res_r.is_final;

endmodule

`default_nettype wire

### src/phtc_alu.sv
// ----------------------------------------------------------------------------
// Program header table checker shared adder
// One 64-bit add/subtract unit with carry out, used for the sequencer's offset, size, address and scan compares.
// ----------------------------------------------------------------------------
`default_nettype none

module phtc_alu (
  input  phtc_pkg::alu_req_t req,
  output phtc_pkg::alu_rsp_t rsp
);
  import phtc_pkg::*;

  logic [WORD_W-1:0] b_eff;
  logic [WORD_W:0]   total;

  assign b_eff = req.sub ? ~req.b : req.b;
  assign total = {1'b0, req.a} + {1'b0, b_eff} + {{WORD_W{1'b0}}, req.sub};

  assign rsp.sum   = total[WORD_W-1:0];
  assign rsp.carry = total[WORD_W];

endmodule

`default_nettype wire

### src/phtc_ctrl.sv
// ----------------------------------------------------------------------------
// Program header table checker sequencer
// Steps each header through the shared adder, keeps the table state and
// load segment store, and scans the store for containment on an error-free last header.
// ----------------------------------------------------------------------------
`default_nettype none
`include "program_header_table_checker_core_macros.svh"

module phtc_ctrl #(
  parameter int unsigned MAX_LOADS = phtc_pkg::MAX_LOADS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  phtc_pkg::item_t     item,
  input  phtc_pkg::cfg_regs_t cfg,
  output logic                res_valid,
  input  logic                res_ready,
  output phtc_pkg::result_t   res,
  output phtc_pkg::alu_req_t  alu_req,
  input  phtc_pkg::alu_rsp_t  alu_rsp
);
  import phtc_pkg::*;

  localparam int unsigned CW = $clog2(MAX_LOADS + 1);
  localparam int unsigned IW = (MAX_LOADS > 1) ? $clog2(MAX_LOADS) : 1;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LOADS);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_C0   = 4'd1;
  localparam logic [3:0] ST_C1   = 4'd2;
  localparam logic [3:0] ST_C2   = 4'd3;
  localparam logic [3:0] ST_C3   = 4'd4;
  localparam logic [3:0] ST_C4   = 4'd5;
  localparam logic [3:0] ST_C5   = 4'd6;
  localparam logic [3:0] ST_C6   = 4'd7;
  localparam logic [3:0] ST_UPD  = 4'd8;
  localparam logic [3:0] ST_WRD  = 4'd9;
  localparam logic [3:0] ST_WA   = 4'd10;
  localparam logic [3:0] ST_WB   = 4'd11;
  localparam logic [3:0] ST_WC   = 4'd12;
  localparam logic [3:0] ST_FIN  = 4'd13;
  localparam logic [3:0] ST_DONE = 4'd14;

  logic [3:0]        state_r, state_nxt;
  item_t             item_r, item_nxt;
  logic [ERR_W-1:0]  err_r, err_nxt;
  logic [WORD_W-1:0] tmp_r, tmp_nxt;
  logic [WORD_W-1:0] am1_r, am1_nxt;
  logic              ok_r, ok_nxt;
  logic              seen_load_r, seen_load_nxt;
  logic              seen_interp_r, seen_interp_nxt;
  logic              seen_phdr_r, seen_phdr_nxt;
  logic              seen_dyn_r, seen_dyn_nxt;
  logic              failed_r, failed_nxt;
  logic [WORD_W-1:0] last_load_r, last_load_nxt;
  logic [WORD_W-1:0] phdr_addr_r, phdr_addr_nxt;
  logic [WORD_W-1:0] phdr_size_r, phdr_size_nxt;
  logic [WORD_W-1:0] dyn_addr_r, dyn_addr_nxt;
  logic [WORD_W-1:0] dyn_size_r, dyn_size_nxt;
  logic [CW-1:0]     load_count_r, load_count_nxt;
  logic [CW-1:0]     widx_r, widx_nxt;
  logic              walk_dyn_r, walk_dyn_nxt;

  logic [2*WORD_W-1:0] seg_mem [MAX_LOADS];
  logic [2*WORD_W-1:0] mem_q;
  logic                mem_we;

  logic              is_load, is_dyn, is_interp, is_shlib, is_phdr, is_invalid;
  logic              store_full, upd_failed;
  logic [ERR_W-1:0]  upd_err;
  logic [WORD_W-1:0] seg_v, seg_m, rng_a, rng_s;
  logic              rng_done, rng_hit, clear_tbl;

  assign is_load    = item_r.seg_type == TY_LOAD;
  assign is_dyn     = item_r.seg_type == TY_DYNAMIC;
  assign is_interp  = item_r.seg_type == TY_INTERP;
  assign is_shlib   = item_r.seg_type == TY_SHLIB;
  assign is_phdr    = item_r.seg_type == TY_PHDR;
  assign is_invalid = (item_r.seg_type > TY_TLS) &&
                      !((item_r.seg_type >= TY_OS_LOW) && (item_r.seg_type <= TY_PROC_HI));
  assign store_full = load_count_r == MAX_CNT;

  assign seg_v = mem_q[2*WORD_W-1:WORD_W];
  assign seg_m = mem_q[WORD_W-1:0];
  assign rng_a = walk_dyn_r ? dyn_addr_r : phdr_addr_r;
  assign rng_s = walk_dyn_r ? dyn_size_r : phdr_size_r;

  always_comb begin
    upd_err = err_r;
    if (is_load && store_full) begin
      upd_err[ERR_STORE_FULL] = 1'b1;
    end
    if (is_dyn && seen_dyn_r) begin
      upd_err[ERR_DUP_DYNAMIC] = 1'b1;
    end
    if (is_interp) begin
      upd_err[ERR_DUP_INTERP]  = seen_interp_r;
      upd_err[ERR_LATE_INTERP] = seen_load_r;
    end
    if (is_shlib) begin
      upd_err[ERR_RESERVED] = 1'b1;
    end
    if (is_phdr) begin
      upd_err[ERR_DUP_PHDR]    = seen_phdr_r;
      upd_err[ERR_LATE_PHDR]   = seen_load_r;
      upd_err[ERR_PHDR_EXTENT] = (item_r.seg_offset != cfg.table_offset) ||
                                 (item_r.seg_file_bytes != cfg.table_bytes);
    end
    if (is_invalid) begin
      upd_err[ERR_INVALID_TYPE] = 1'b1;
    end
    if (is_interp && !failed_r && (upd_err == '0) && !item_r.interp_terminated) begin
      upd_err[ERR_INTERP_TERM] = 1'b1;
    end
    upd_failed = failed_r || (upd_err != '0);
  end

  always_comb begin
    state_nxt       = state_r;
    item_nxt        = item_r;
    err_nxt         = err_r;
    tmp_nxt         = tmp_r;
    am1_nxt         = am1_r;
    ok_nxt          = ok_r;
    seen_load_nxt   = seen_load_r;
    seen_interp_nxt = seen_interp_r;
    seen_phdr_nxt   = seen_phdr_r;
    seen_dyn_nxt    = seen_dyn_r;
    failed_nxt      = failed_r;
    last_load_nxt   = last_load_r;
    phdr_addr_nxt   = phdr_addr_r;
    phdr_size_nxt   = phdr_size_r;
    dyn_addr_nxt    = dyn_addr_r;
    dyn_size_nxt    = dyn_size_r;
    load_count_nxt  = load_count_r;
    widx_nxt        = widx_r;
    walk_dyn_nxt    = walk_dyn_r;
    mem_we          = 1'b0;
    rng_done        = 1'b0;
    rng_hit         = 1'b0;
    clear_tbl       = 1'b0;
    alu_req.a       = '0;
    alu_req.b       = '0;
    alu_req.sub     = 1'b1;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = item;
          err_nxt   = '0;
          state_nxt = ST_C0;
        end
      end
      ST_C0: begin
        alu_req.a = cfg.file_size;
        alu_req.b = item_r.seg_offset;
        tmp_nxt   = alu_rsp.sum;
        if (!alu_rsp.carry || (alu_rsp.sum == '0)) begin
          err_nxt[ERR_BEYOND_FILE] = 1'b1;
        end
        state_nxt = ST_C1;
      end
      ST_C1: begin
        alu_req.a = tmp_r;
        alu_req.b = item_r.seg_file_bytes;
        if (!alu_rsp.carry) begin
          err_nxt[ERR_BEYOND_FILE] = 1'b1;
        end
        state_nxt = ST_C2;
      end
      ST_C2: begin
        alu_req.a   = item_r.seg_address;
        alu_req.b   = item_r.seg_mem_bytes;
        alu_req.sub = 1'b0;
        if (alu_rsp.carry) begin
          err_nxt[ERR_ADDR_WRAP] = 1'b1;
        end
        state_nxt = ST_C3;
      end
      ST_C3: begin
        alu_req.a = item_r.seg_address;
        alu_req.b = last_load_r;
        if (is_load && !alu_rsp.carry) begin
          err_nxt[ERR_LOAD_ORDER] = 1'b1;
        end
        state_nxt = ST_C4;
      end
      ST_C4: begin
        alu_req.a = item_r.seg_mem_bytes;
        alu_req.b = item_r.seg_file_bytes;
        if (is_load && !alu_rsp.carry) begin
          err_nxt[ERR_MEM_SMALL] = 1'b1;
        end
        state_nxt = ST_C5;
      end
      ST_C5: begin
        alu_req.a = item_r.seg_alignment;
        alu_req.b = WORD_W'(1);
        am1_nxt   = alu_rsp.sum;
        state_nxt = ST_C6;
      end
      ST_C6: begin
        alu_req.a = item_r.seg_address;
        alu_req.b = item_r.seg_offset;
        if (is_load && (item_r.seg_alignment[WORD_W-1:1] != '0) &&
            (((item_r.seg_alignment & am1_r) != '0) || ((alu_rsp.sum & am1_r) != '0))) begin
          err_nxt[ERR_ALIGN] = 1'b1;
        end
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        err_nxt    = upd_err;
        failed_nxt = upd_failed;
        ok_nxt     = 1'b0;
        if (is_load) begin
          seen_load_nxt = 1'b1;
          last_load_nxt = item_r.seg_address;
          if (!store_full) begin
            mem_we         = 1'b1;
            load_count_nxt = load_count_r + CW'(1);
          end
        end
        if (is_dyn) begin
          seen_dyn_nxt = 1'b1;
          dyn_addr_nxt = item_r.seg_address;
          dyn_size_nxt = item_r.seg_mem_bytes;
        end
        if (is_interp) begin
          seen_interp_nxt = 1'b1;
        end
        if (is_phdr) begin
          seen_phdr_nxt = 1'b1;
          phdr_addr_nxt = item_r.seg_address;
          phdr_size_nxt = item_r.seg_mem_bytes;
        end
        state_nxt = ST_DONE;
        if (item_r.final_header) begin
          if (!upd_failed && (seen_phdr_nxt || seen_dyn_nxt)) begin
            walk_dyn_nxt = !seen_phdr_nxt;
            widx_nxt     = '0;
            state_nxt    = ST_WRD;
          end else begin
            ok_nxt    = !upd_failed;
            clear_tbl = 1'b1;
          end
        end
      end
      ST_WRD: begin
        if (widx_r == load_count_r) begin
          rng_done = 1'b1;
        end else begin
          state_nxt = ST_WA;
        end
      end
      ST_WA: begin
        alu_req.a = rng_a;
        alu_req.b = seg_v;
        tmp_nxt   = alu_rsp.sum;
        if (alu_rsp.carry) begin
          state_nxt = ST_WB;
        end else begin
          widx_nxt  = widx_r + CW'(1);
          state_nxt = ST_WRD;
        end
      end
      ST_WB: begin
        alu_req.a = seg_m;
        alu_req.b = tmp_r;
        tmp_nxt   = alu_rsp.sum;
        if (alu_rsp.carry) begin
          state_nxt = ST_WC;
        end else begin
          widx_nxt  = widx_r + CW'(1);
          state_nxt = ST_WRD;
        end
      end
      ST_WC: begin
        alu_req.a = tmp_r;
        alu_req.b = rng_s;
        if (alu_rsp.carry) begin
          rng_done = 1'b1;
          rng_hit  = 1'b1;
        end else begin
          widx_nxt  = widx_r + CW'(1);
          state_nxt = ST_WRD;
        end
      end
      ST_FIN: begin
        ok_nxt    = err_r == '0;
        clear_tbl = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (rng_done) begin
      if (!rng_hit && walk_dyn_r) begin
        err_nxt[ERR_DYN_OUTSIDE] = 1'b1;
      end
      if (!rng_hit && !walk_dyn_r) begin
        err_nxt[ERR_PHDR_OUTSIDE] = 1'b1;
      end
      if (!walk_dyn_r && seen_dyn_r) begin
        walk_dyn_nxt = 1'b1;
        widx_nxt     = '0;
        state_nxt    = ST_WRD;
      end else begin
        state_nxt = ST_FIN;
      end
    end

    if (clear_tbl) begin
      seen_load_nxt   = 1'b0;
      seen_interp_nxt = 1'b0;
      seen_phdr_nxt   = 1'b0;
      seen_dyn_nxt    = 1'b0;
      failed_nxt      = 1'b0;
      last_load_nxt   = '0;
      phdr_addr_nxt   = '0;
      phdr_size_nxt   = '0;
      dyn_addr_nxt    = '0;
      dyn_size_nxt    = '0;
      load_count_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      seen_load_r   <= 1'b0;
      seen_interp_r <= 1'b0;
      seen_phdr_r   <= 1'b0;
      seen_dyn_r    <= 1'b0;
      failed_r      <= 1'b0;
      last_load_r   <= '0;
      load_count_r  <= '0;
    end else begin
      state_r       <= state_nxt;
      seen_load_r   <= seen_load_nxt;
      seen_interp_r <= seen_interp_nxt;
      seen_phdr_r   <= seen_phdr_nxt;
      seen_dyn_r    <= seen_dyn_nxt;
      failed_r      <= failed_nxt;
      last_load_r   <= last_load_nxt;
      load_count_r  <= load_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    err_r       <= err_nxt;
    tmp_r       <= tmp_nxt;
    am1_r       <= am1_nxt;
    ok_r        <= ok_nxt;
    phdr_addr_r <= phdr_addr_nxt;
    phdr_size_r <= phdr_size_nxt;
    dyn_addr_r  <= dyn_addr_nxt;
    dyn_size_r  <= dyn_size_nxt;
    widx_r      <= widx_nxt;
    walk_dyn_r  <= walk_dyn_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      seg_mem[load_count_r[IW-1:0]] <= {item_r.seg_address, item_r.seg_mem_bytes};
    end
    mem_q <= seg_mem[widx_r[IW-1:0]];
  end

  assign in_ready         = state_r == ST_IDLE;
  assign res_valid        = state_r == ST_DONE;
  assign res.error_bits   = err_r;
  assign res.table_ok     = ok_r;
  assign res.is_final     = item_r.final_header;

  `PHTC_ASSERT_ALWAYS(a_count_bound, load_count_r <= MAX_CNT, "load count exceeds store depth")
  `PHTC_ASSERT_IMP(a_walk_bound, (state_r == ST_WRD || state_r == ST_WA || state_r == ST_WB || state_r == ST_WC), widx_r <= load_count_r, "scan index past stored loads")
  `PHTC_ASSERT_IMP(a_ok_final, res_valid && res.table_ok, item_r.final_header, "table pass flagged on a non-final header")
  `PHTC_ASSERT_IMP(a_final_clear, res_valid && item_r.final_header, load_count_r == '0 && !failed_r && !seen_load_r, "table state not cleared after final header")
  `PHTC_ASSERT_NXT(a_done_idle, res_valid && res_ready, in_ready, "sequencer did not return to idle after result transfer")

endmodule

`default_nettype wire

### verif/program_header_table_checker_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Program header table checker testbench
// Sends decoded program headers through the input channel and checks every
// per-header result against a local model of the rule checks and table state
// (a fixed result for some hand-picked rows). Hand-picked headers come first,
// then random tables under several register settings, random gaps on both channels.
// ----------------------------------------------------------------------------

module program_header_table_checker_core_tb;
  import phtc_pkg::*;

  localparam int unsigned MAX_LOADS       = MAX_LOADS_DEF;
  localparam int unsigned ITEMS_PER_PHASE = 210;
  localparam int unsigned N_PHASES        = 6;
  localparam int unsigned STUCK_LIMIT     = 5000;

  localparam logic [TYPE_W-1:0] TY_NULL      = 32'd0;
  localparam logic [TYPE_W-1:0] TY_NOTE      = 32'd4;
  localparam logic [TYPE_W-1:0] TY_GNU_STACK = 32'h6474_E551;

  typedef struct {
    item_t   hdr;
    bit      typed;
    result_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [WORD_W-1:0] pwdata;
  logic [WORD_W-1:0] prdata;
  logic pready;

  phtc_in_if  in_ch ();
  phtc_out_if out_ch ();

  program_header_table_checker_core #(
    .MAX_LOADS (MAX_LOADS)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Model of the table state and the register mirror.
  cfg_regs_t cur_regs = '0;
  bit p_seen_load = 1'b0;
  bit p_seen_interp = 1'b0;
  bit p_seen_phdr = 1'b0;
  bit p_seen_dyn = 1'b0;
  bit p_failed = 1'b0;
  logic [WORD_W-1:0] p_last_load = '0;
  logic [WORD_W-1:0] p_phdr_addr = '0;
  logic [WORD_W-1:0] p_phdr_size = '0;
  logic [WORD_W-1:0] p_dyn_addr = '0;
  logic [WORD_W-1:0] p_dyn_size = '0;
  int unsigned p_load_cnt = 0;
  logic [WORD_W-1:0] p_load_addr [MAX_LOADS];
  logic [WORD_W-1:0] p_load_size [MAX_LOADS];

  result_t verdicts [$];
  result_t want;
  row_t rows [$];
  item_t table_q [$];

  int unsigned in_idle_pct = 0;
  int unsigned out_idle_pct = 0;
  int unsigned stall_left = 0;
  int unsigned stuck_cycles = 0;
  int unsigned n_headers = 0;
  int unsigned n_results = 0;
  int unsigned n_tables = 0;
  int unsigned n_passed = 0;
  int unsigned n_mismatch = 0;

  function automatic logic [ERR_W-1:0] flag(int unsigned pos);
    return ERR_W'(1) << pos;
  endfunction

  function automatic void clear_table();
    p_seen_load = 1'b0;
    p_seen_interp = 1'b0;
    p_seen_phdr = 1'b0;
    p_seen_dyn = 1'b0;
    p_failed = 1'b0;
    p_last_load = '0;
    p_phdr_addr = '0;
    p_phdr_size = '0;
    p_dyn_addr = '0;
    p_dyn_size = '0;
    p_load_cnt = 0;
  endfunction

  function automatic bit span_in_loads(logic [WORD_W-1:0] a, logic [WORD_W-1:0] s);
    logic [WORD_W-1:0] rel;
    for (int i = 0; i < p_load_cnt; i++) begin
      if (a >= p_load_addr[i]) begin
        rel = a - p_load_addr[i];
        if (rel <= p_load_size[i] && s <= p_load_size[i] - rel) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic result_t score_header(item_t h);
    logic [ERR_W-1:0] err;
    logic [WORD_W-1:0] gap;
    result_t r;
    err = '0;
    if (h.seg_offset >= cur_regs.file_size ||
        cur_regs.file_size - h.seg_offset < h.seg_file_bytes) err[ERR_BEYOND_FILE] = 1'b1;
    if (h.seg_address > ~h.seg_mem_bytes) err[ERR_ADDR_WRAP] = 1'b1;
    case (h.seg_type)
      TY_LOAD: begin
        p_seen_load = 1'b1;
        if (h.seg_address < p_last_load) err[ERR_LOAD_ORDER] = 1'b1;
        if (h.seg_mem_bytes < h.seg_file_bytes) err[ERR_MEM_SMALL] = 1'b1;
        if (h.seg_alignment > 64'd1) begin
          gap = (h.seg_address > h.seg_offset) ? h.seg_address - h.seg_offset
                                               : h.seg_offset - h.seg_address;
          if ((h.seg_alignment & (h.seg_alignment - 64'd1)) != '0 ||
              gap % h.seg_alignment != '0) err[ERR_ALIGN] = 1'b1;
        end
        p_last_load = h.seg_address;
        if (p_load_cnt < MAX_LOADS) begin
          p_load_addr[p_load_cnt] = h.seg_address;
          p_load_size[p_load_cnt] = h.seg_mem_bytes;
          p_load_cnt++;
        end else begin
          err[ERR_STORE_FULL] = 1'b1;
        end
      end
      TY_DYNAMIC: begin
        if (p_seen_dyn) err[ERR_DUP_DYNAMIC] = 1'b1;
        p_seen_dyn = 1'b1;
        p_dyn_addr = h.seg_address;
        p_dyn_size = h.seg_mem_bytes;
      end
      TY_INTERP: begin
        if (p_seen_interp) err[ERR_DUP_INTERP] = 1'b1;
        if (p_seen_load) err[ERR_LATE_INTERP] = 1'b1;
        p_seen_interp = 1'b1;
        if (!p_failed && err == '0 && !h.interp_terminated) err[ERR_INTERP_TERM] = 1'b1;
      end
      TY_SHLIB: err[ERR_RESERVED] = 1'b1;
      TY_PHDR: begin
        if (p_seen_phdr) err[ERR_DUP_PHDR] = 1'b1;
        if (p_seen_load) err[ERR_LATE_PHDR] = 1'b1;
        p_seen_phdr = 1'b1;
        p_phdr_addr = h.seg_address;
        p_phdr_size = h.seg_mem_bytes;
        if (h.seg_offset != cur_regs.table_offset ||
            h.seg_file_bytes != cur_regs.table_bytes) err[ERR_PHDR_EXTENT] = 1'b1;
      end
      default: begin
        if (h.seg_type > TY_TLS && !(h.seg_type >= TY_OS_LOW && h.seg_type <= TY_PROC_HI))
          err[ERR_INVALID_TYPE] = 1'b1;
      end
    endcase
    if (err != '0) p_failed = 1'b1;
    r.table_ok = 1'b0;
    if (h.final_header) begin
      if (!p_failed) begin
        if (p_seen_phdr && !span_in_loads(p_phdr_addr, p_phdr_size))
          err[ERR_PHDR_OUTSIDE] = 1'b1;
        if (p_seen_dyn && !span_in_loads(p_dyn_addr, p_dyn_size))
          err[ERR_DYN_OUTSIDE] = 1'b1;
        if (err != '0) p_failed = 1'b1;
      end
      r.table_ok = !p_failed;
      clear_table();
    end
    r.error_bits = err;
    r.is_final = h.final_header;
    return r;
  endfunction

  function automatic void add_row(logic [TYPE_W-1:0] ty, logic [WORD_W-1:0] off,
                                  logic [WORD_W-1:0] fb, logic [WORD_W-1:0] addr,
                                  logic [WORD_W-1:0] mb, logic [WORD_W-1:0] al,
                                  bit term, bit fin, bit typed,
                                  logic [ERR_W-1:0] err, bit ok);
    row_t r;
    r.hdr = '{ty, off, fb, addr, mb, al, term, fin};
    r.typed = typed;
    r.want = '{err, ok, fin};
    rows.push_back(r);
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 64'd1;
      2: return '1;
      3: return 64'hFFFF_FFFF_FFFF_FFFE;
      4: return 64'h8000_0000_0000_0000;
      5: return 64'($urandom_range(0, 'hFFFF));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [TYPE_W-1:0] pick_type();
    case ($urandom_range(0, 11))
      0: return TY_LOAD;
      1: return TY_DYNAMIC;
      2: return TY_INTERP;
      3: return TY_SHLIB;
      4: return TY_PHDR;
      5: return TY_TLS;
      6: return TYPE_W'($urandom_range(0, 9));
      7: return TY_OS_LOW;
      8: return TY_PROC_HI;
      9: return TY_OS_LOW - 32'd1;
      10: return TY_PROC_HI + 32'd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic item_t noise_header();
    item_t h;
    h.seg_type = pick_type();
    h.seg_offset = pick_word();
    h.seg_file_bytes = pick_word();
    h.seg_address = pick_word();
    h.seg_mem_bytes = pick_word();
    h.seg_alignment = pick_word();
    h.interp_terminated = $urandom_range(0, 1);
    h.final_header = ($urandom_range(0, 3) == 0);
    return h;
  endfunction

  // Builds a table meant to pass every rule; store overflow or unfit registers fail it.
  function automatic void plan_table();
    item_t h;
    logic [WORD_W-1:0] base;
    logic [WORD_W-1:0] load_addr [$];
    int unsigned n_loads;
    int unsigned j;
    table_q.delete();
    base = {1'b0, 11'($urandom), 32'($urandom), 20'h0};
    n_loads = ($urandom_range(0, 39) == 0) ? $urandom_range(MAX_LOADS - 4, MAX_LOADS + 4)
                                           : $urandom_range(1, 6);
    if ($urandom_range(0, 2) != 0) begin
      h = '0;
      h.seg_type = TY_PHDR;
      h.seg_offset = cur_regs.table_offset;
      h.seg_file_bytes = cur_regs.table_bytes;
      h.seg_address = base + cur_regs.table_offset;
      h.seg_mem_bytes = cur_regs.table_bytes;
      h.seg_alignment = 64'd8;
      table_q.push_back(h);
    end
    if ($urandom_range(0, 1) != 0) begin
      h = '0;
      h.seg_type = TY_INTERP;
      h.seg_offset = 64'h200 + $urandom_range(0, 'h100);
      h.seg_file_bytes = $urandom_range(1, 'h40);
      h.seg_address = base + h.seg_offset;
      h.seg_mem_bytes = h.seg_file_bytes;
      h.seg_alignment = 64'd1;
      h.interp_terminated = 1'b1;
      table_q.push_back(h);
    end
    for (int i = 0; i < n_loads; i++) begin
      h = '0;
      h.seg_type = TY_LOAD;
      h.seg_offset = 64'(i % 8) << 12;
      h.seg_file_bytes = $urandom_range(0, 'h800);
      h.seg_address = base + (64'(i) << 16) + h.seg_offset;
      h.seg_mem_bytes = h.seg_file_bytes + $urandom_range('h800, 'h4000);
      case ($urandom_range(0, 3))
        0: h.seg_alignment = 64'd0;
        1: h.seg_alignment = 64'd1;
        2: h.seg_alignment = 64'h1000;
        default: h.seg_alignment = 64'h1_0000;
      endcase
      table_q.push_back(h);
      load_addr.push_back(h.seg_address);
    end
    if ($urandom_range(0, 1) != 0) begin
      j = $urandom_range(0, n_loads - 1);
      h = '0;
      h.seg_type = TY_DYNAMIC;
      h.seg_offset = 64'h3000 + $urandom_range(0, 'h800);
      h.seg_file_bytes = $urandom_range(0, 'h200);
      h.seg_address = load_addr[j] + $urandom_range(0, 'h400);
      h.seg_mem_bytes = $urandom_range(0, 'h400);
      h.seg_alignment = 64'd8;
      table_q.push_back(h);
    end
    repeat ($urandom_range(0, 2)) begin
      h = '0;
      case ($urandom_range(0, 3))
        0: h.seg_type = TY_NULL;
        1: h.seg_type = TY_NOTE;
        2: h.seg_type = TY_TLS;
        default: h.seg_type = TY_OS_LOW + $urandom_range(0, 'h1FFF_FFFF);
      endcase
      h.seg_offset = 64'h100;
      h.seg_file_bytes = 64'h10;
      h.seg_address = base + 64'h100;
      h.seg_mem_bytes = 64'h10;
      h.seg_alignment = 64'd4;
      table_q.push_back(h);
    end
  endfunction

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [WORD_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({idx, 3'b000});
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_FILE_SIZE: cur_regs.file_size = value;
      REG_TABLE_OFFSET: cur_regs.table_offset = value;
      REG_TABLE_BYTES: cur_regs.table_bytes = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic send_header(item_t h, bit typed, result_t fixed);
    result_t r;
    if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.seg_type <= h.seg_type;
    in_ch.seg_offset <= h.seg_offset;
    in_ch.seg_file_bytes <= h.seg_file_bytes;
    in_ch.seg_address <= h.seg_address;
    in_ch.seg_mem_bytes <= h.seg_mem_bytes;
    in_ch.seg_alignment <= h.seg_alignment;
    in_ch.interp_terminated <= h.interp_terminated;
    in_ch.final_header <= h.final_header;
    do @(posedge clk); while (!in_ch.ready);
    r = score_header(h);
    verdicts.push_back(typed ? fixed : r);
    n_headers++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (verdicts.size() != 0);
  endtask

  always @(negedge clk) begin
    if (stall_left == 0 && out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct)
      stall_left = $urandom_range(1, 8);
    if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (verdicts.size() == 0) begin
          $display("%0t: unexpected result, error_bits %05h table_ok %0b is_final %0b",
                   $time, out_ch.error_bits, out_ch.table_ok, out_ch.is_final);
          n_mismatch++;
        end else begin
          want = verdicts.pop_front();
          if (out_ch.error_bits !== want.error_bits) begin
            $display("%0t: error_bits expected %05h got %05h",
                     $time, want.error_bits, out_ch.error_bits);
            n_mismatch++;
          end
          if (out_ch.table_ok !== want.table_ok) begin
            $display("%0t: table_ok expected %0b got %0b", $time, want.table_ok, out_ch.table_ok);
            n_mismatch++;
          end
          if (out_ch.is_final !== want.is_final) begin
            $display("%0t: is_final expected %0b got %0b", $time, want.is_final, out_ch.is_final);
            n_mismatch++;
          end
          if (want.is_final) n_tables++;
          if (want.table_ok) n_passed++;
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || (psel && penable))
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t: timeout, no transfer for %0d cycles, %0d results outstanding",
                 $time, STUCK_LIMIT, verdicts.size());
        $display("program_header_table_checker_core_tb failed");
        $finish;
      end
    end
  end

  initial begin
    item_t h;
    int unsigned start;
    int unsigned n;
    int unsigned k;
    in_ch.valid = 1'b0;
    in_ch.seg_type = '0;
    in_ch.seg_offset = '0;
    in_ch.seg_file_bytes = '0;
    in_ch.seg_address = '0;
    in_ch.seg_mem_bytes = '0;
    in_ch.seg_alignment = '0;
    in_ch.interp_terminated = 1'b0;
    in_ch.final_header = 1'b0;
    out_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;

    // A clean table that passes, then rule breaks, then the final range checks.
    add_row(TY_PHDR, 64'h40, 64'he0, 64'h40_0040, 64'he0, 64'h8, 0, 0, 0, '0, 0);
    add_row(TY_INTERP, 64'h120, 64'h1c, 64'h40_0120, 64'h1c, 64'h1, 1, 0, 0, '0, 0);
    add_row(TY_LOAD, 64'h0, 64'h1000, 64'h40_0000, 64'h1000, 64'h1000, 0, 0, 0, '0, 0);
    add_row(TY_LOAD, 64'h1000, 64'h2000, 64'h40_1000, 64'h3000, 64'h1000, 0, 0, 0, '0, 0);
    add_row(TY_DYNAMIC, 64'h2000, 64'h100, 64'h40_2000, 64'h100, 64'h8, 0, 0, 0, '0, 0);
    add_row(TY_NOTE, 64'h200, 64'h20, 64'h40_0200, 64'h20, 64'h4, 0, 0, 0, '0, 0);
    add_row(TY_TLS, 64'h3000, 64'h10, 64'h40_3000, 64'h20, 64'h8, 0, 0, 0, '0, 0);
    add_row(TY_GNU_STACK, 64'h0, 64'h0, 64'h0, 64'h0, 64'h10, 0, 0, 0, '0, 0);
    add_row(TY_PROC_HI, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 0, 1, 1, '0, 1);
    add_row(TY_NULL, '1, 64'h0, '1, 64'h1, 64'h0, 0, 0, 1,
            flag(ERR_BEYOND_FILE) | flag(ERR_ADDR_WRAP), 0);
    add_row(TY_SHLIB, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 0, 0, 1, flag(ERR_RESERVED), 0);
    add_row(TY_TLS + 32'd1, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 0, 0, 1,
            flag(ERR_INVALID_TYPE), 0);
    add_row(TY_OS_LOW - 32'd1, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 0, 0, 1,
            flag(ERR_INVALID_TYPE), 0);
    add_row('1, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 0, 0, 1, flag(ERR_INVALID_TYPE), 0);
    add_row(TY_LOAD, 64'h100, 64'h20, 64'h1_0000, 64'h10, 64'h3, 0, 0, 0, '0, 0);
    add_row(TY_LOAD, 64'h0, 64'h0, 64'h8000, 64'h0, 64'h1000, 0, 0, 0, '0, 0);
    add_row(TY_PHDR, 64'h41, 64'he0, 64'h0, 64'h0, 64'h8, 0, 0, 0, '0, 0);
    add_row(TY_PHDR, 64'h41, 64'he0, 64'h0, 64'h0, 64'h8, 0, 0, 0, '0, 0);
    add_row(TY_INTERP, 64'h100, 64'h10, 64'h0, 64'h10, 64'h1, 0, 0, 0, '0, 0);
    add_row(TY_DYNAMIC, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 0, 0, 0, '0, 0);
    add_row(TY_DYNAMIC, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 0, 1, 0, '0, 0);
    add_row(TY_INTERP, 64'h100, 64'h10, 64'h0, 64'h10, 64'h1, 0, 0, 1,
            flag(ERR_INTERP_TERM), 0);
    add_row(TY_NULL, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 0, 1, 1, '0, 0);
    add_row(TY_PHDR, 64'h40, 64'he0, 64'h50_0000, 64'he0, 64'h8, 0, 0, 0, '0, 0);
    add_row(TY_DYNAMIC, 64'h2000, 64'h100, 64'h90_0000, 64'h100, 64'h8, 0, 0, 0, '0, 0);
    add_row(TY_LOAD, 64'h0, 64'h1000, 64'h40_0000, 64'h1000, 64'h1000, 0, 1, 1,
            flag(ERR_PHDR_OUTSIDE) | flag(ERR_DYN_OUTSIDE), 0);

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_reg(REG_FILE_SIZE, 64'h1_0000);
    write_reg(REG_TABLE_OFFSET, 64'h40);
    write_reg(REG_TABLE_BYTES, 64'he0);
    in_idle_pct = 20;
    out_idle_pct = 20;
    foreach (rows[r]) send_header(rows[r].hdr, rows[r].typed, rows[r].want);

    for (int phase = 0; phase < N_PHASES; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          write_reg(REG_FILE_SIZE, '1);
          write_reg(REG_TABLE_OFFSET, '1);
          write_reg(REG_TABLE_BYTES, '1);
        end
        1: begin
          write_reg(REG_FILE_SIZE, '0);
          write_reg(REG_TABLE_OFFSET, '0);
          write_reg(REG_TABLE_BYTES, '0);
        end
        default: begin
          write_reg(REG_FILE_SIZE, (phase == N_PHASES - 1) ? '1
                                   : 64'($urandom_range('h1_0000, 'hFF_FFFF)));
          write_reg(REG_TABLE_OFFSET, 64'($urandom_range('h40, 'h100)));
          write_reg(REG_TABLE_BYTES, 64'h38 * $urandom_range(1, 16));
        end
      endcase
      start = n_headers;
      while (n_headers - start < ITEMS_PER_PHASE) begin
        if (phase == N_PHASES - 1) begin
          in_idle_pct = 0;
          out_idle_pct = 0;
        end else begin
          in_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
          out_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
        end
        if ($urandom_range(0, 4) == 0) begin
          n = $urandom_range(1, 5);
          for (int i = 0; i < n; i++) begin
            h = noise_header();
            if (i == n - 1) h.final_header = 1'b1;
            send_header(h, 1'b0, '0);
          end
        end else begin
          plan_table();
          if ($urandom_range(0, 9) < 4) begin
            k = $urandom_range(0, table_q.size() - 1);
            case ($urandom_range(0, 8))
              0: table_q[k].seg_type = pick_type();
              1: table_q[k].seg_offset = pick_word();
              2: table_q[k].seg_file_bytes = pick_word();
              3: table_q[k].seg_address = pick_word();
              4: table_q[k].seg_mem_bytes = pick_word();
              5: table_q[k].seg_alignment = pick_word();
              6: table_q[k].interp_terminated = 1'b0;
              7: table_q.insert(k, table_q[k]);
              default: begin
                h = table_q[k];
                table_q.delete(k);
                table_q.push_back(h);
              end
            endcase
          end
          table_q[table_q.size() - 1].final_header = 1'b1;
          foreach (table_q[i]) send_header(table_q[i], 1'b0, '0);
        end
      end
    end

    wait_drained();
    repeat (40) @(negedge clk);
    $display("Checked %0d results for %0d headers under %0d register settings.",
             n_results, n_headers, N_PHASES + 1);
    $display("Tables closed: %0d, of which %0d passed every rule.", n_tables, n_passed);
    if (n_mismatch == 0 && verdicts.size() == 0) begin
      $display("program_header_table_checker_core_tb passed");
    end else begin
      $display("program_header_table_checker_core_tb failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/phtc_pkg.sv
src/phtc_if.sv
src/phtc_alu.sv
src/phtc_ctrl.sv
src/program_header_table_checker_core.sv
verif/program_header_table_checker_core_tb.sv
